FILE: hdl/hbd_pkg.sv
// Types and constants shared by the Huffman bitstream decoder files.
package hbd_pkg;

  localparam int unsigned CodeW  = 32;
  localparam int unsigned LenW   = 6;
  localparam int unsigned SymW   = 16;
  localparam int unsigned CountW = 24;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned EntryW = SymW + LenW + CodeW;
  localparam logic [LenW-1:0] MaxLenReset = 6'd16;
  localparam logic [LenW-1:0] MaxLenLimit = 6'd32;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_START = 2'd2,
    OP_DATA  = 2'd3
  } hbd_op_e;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DECODING = 2'd1,
    PH_DONE     = 2'd2,
    PH_HALTED   = 2'd3
  } hbd_phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LRD,
    ST_LCMP,
    ST_LAPP,
    ST_SHIFT,
    ST_RD,
    ST_CMP,
    ST_HIT,
    ST_MISS,
    ST_NEXT,
    ST_FLUSH
  } hbd_state_e;

  typedef struct packed {
    hbd_op_e           opcode;
    logic [SymW-1:0]   entry_symbol;
    logic [LenW-1:0]   entry_length;
    logic [CodeW-1:0]  entry_code;
    logic [CountW-1:0] symbol_count;
    logic [ByteW-1:0]  data_byte;
  } hbd_in_t;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            status;
    logic            frame_done;
    logic            last;
  } hbd_out_t;

  typedef struct packed {
    logic [SymW-1:0]  symbol;
    logic [LenW-1:0]  length;
    logic [CodeW-1:0] code;
  } hbd_entry_t;

endpackage

FILE: hdl/hbd_if.sv
// Valid/ready channel interfaces for decoder requests and results.
interface hbd_in_if
  import hbd_pkg::*;
();
  logic    valid;
  logic    ready;
  hbd_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface hbd_out_if
  import hbd_pkg::*;
();
  logic     valid;
  logic     ready;
  hbd_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/huffman_bitstream_decoder_top.sv
// Huffman bitstream decoder: code table memory, bit-serial matcher and result staging.
//
//   channel   dir  handshake          payload
//   in_i      in   valid/ready        hbd_in_t (opcode and entry/frame/data fields)
//   out_o     out  valid/ready        hbd_out_t (symbol, status, frame_done, last)
//   cfg       in   cfg_we_i           cfg_data_i = max_code_len
//
// Clear, start and out-of-frame data requests complete in the idle state. A load searches the
// table for a duplicate through the memory's single read port. A data byte is decoded bit by
// bit: each bit scans the stored entries, one read and one compare each. Reset is asynchronous
// and clears the state, phase, counters, partial code and valid flags; the table contents are
// undefined until loaded. A stalled output holds the scan at a result.
module huffman_bitstream_decoder_top
  import hbd_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  hbd_in_if.sink           in_i,
  hbd_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic [LenW-1:0]  cfg_data_i
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] Full = CW'(TABLE_ENTRIES);

  hbd_entry_t mem [TABLE_ENTRIES];
  hbd_entry_t rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  hbd_entry_t    mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  hbd_state_e        state_q, state_d;
  hbd_phase_e        phase_q, phase_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CodeW-1:0]  pcode_q, pcode_d;
  logic [LenW-1:0]   plen_q, plen_d;
  logic [CountW-1:0] left_q, left_d;
  logic [LenW-1:0]   maxlen_q;
  logic [ByteW-1:0]  byte_q, byte_d;
  logic [2:0]        bitn_q, bitn_d;
  hbd_entry_t        ld_q, ld_d;
  logic [SymW-1:0]   hitsym_q, hitsym_d;
  logic              pend_valid_q, pend_valid_d;
  hbd_out_t          pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  hbd_out_t          out_q, out_d;

  logic [LenW-1:0]   eff_max;
  logic              out_free;
  logic [CW-1:0]     idx_inc;
  logic [CountW-1:0] left_dec;
  logic              entry_hit;

  assign eff_max   = (maxlen_q == '0) ? LenW'(1) :
                     (maxlen_q > MaxLenLimit) ? MaxLenLimit : maxlen_q;
  assign out_free  = !out_valid_q || out_o.ready;
  assign idx_inc   = idx_q + CW'(1);
  assign left_dec  = left_q - CountW'(1);
  assign entry_hit = (rd_q.code == pcode_q) && (rd_q.length == plen_q);

  assign in_i.ready    = (state_q == ST_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    count_d      = count_q;
    idx_d        = idx_q;
    pcode_d      = pcode_q;
    plen_d       = plen_q;
    left_d       = left_q;
    byte_d       = byte_q;
    bitn_d       = bitn_q;
    ld_d         = ld_q;
    hitsym_d     = hitsym_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_d        = out_q;
    mem_we       = 1'b0;
    mem_waddr    = idx_q[AW-1:0];
    mem_wdata    = ld_q;
    mem_raddr    = idx_q[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          unique case (in_i.payload.opcode)
            OP_CLEAR: count_d = '0;
            OP_LOAD: begin
              ld_d.symbol = in_i.payload.entry_symbol;
              ld_d.length = in_i.payload.entry_length;
              ld_d.code   = in_i.payload.entry_code;
              idx_d       = '0;
              state_d     = (count_q == '0) ? ST_LAPP : ST_LRD;
            end
            OP_START: begin
              left_d  = in_i.payload.symbol_count;
              pcode_d = '0;
              plen_d  = '0;
              phase_d = (in_i.payload.symbol_count == '0) ? PH_DONE : PH_DECODING;
            end
            OP_DATA: begin
              if (phase_q == PH_DECODING) begin
                byte_d  = in_i.payload.data_byte;
                bitn_d  = 3'd7;
                state_d = ST_SHIFT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LRD: state_d = ST_LCMP;
      ST_LCMP: begin
        if (rd_q.code == ld_q.code && rd_q.length == ld_q.length) begin
          // duplicate: last load wins
          mem_we  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          idx_d   = idx_inc;
          state_d = (idx_inc == count_q) ? ST_LAPP : ST_LRD;
        end
      end
      ST_LAPP: begin
        if (count_q < Full) begin
          mem_we    = 1'b1;
          mem_waddr = count_q[AW-1:0];
          count_d   = count_q + CW'(1);
        end
        state_d = ST_IDLE;
      end
      ST_SHIFT: begin
        pcode_d = {pcode_q[CodeW-2:0], byte_q[bitn_q]};
        plen_d  = plen_q + LenW'(1);
        idx_d   = '0;
        state_d = (count_q == '0) ? ST_MISS : ST_RD;
      end
      ST_RD: state_d = ST_CMP;
      ST_CMP: begin
        if (entry_hit) begin
          hitsym_d = rd_q.symbol;
          state_d  = ST_HIT;
        end else begin
          idx_d   = idx_inc;
          state_d = (idx_inc == count_q) ? ST_MISS : ST_RD;
        end
      end
      ST_HIT: begin
        if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_d       = pend_q;
          end
          pend_valid_d      = 1'b1;
          pend_d.symbol     = hitsym_q;
          pend_d.status     = 1'b0;
          pend_d.frame_done = (left_dec == '0);
          pend_d.last       = 1'b0;
          left_d            = left_dec;
          pcode_d           = '0;
          plen_d            = '0;
          if (left_dec == '0) phase_d = PH_DONE;
          state_d = ST_NEXT;
        end
      end
      ST_MISS: begin
        if (plen_q < eff_max) begin
          state_d = ST_NEXT;
        end else if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_d       = pend_q;
          end
          pend_valid_d      = 1'b1;
          pend_d.symbol     = '0;
          pend_d.status     = 1'b1;
          pend_d.frame_done = 1'b0;
          pend_d.last       = 1'b0;
          pcode_d           = '0;
          plen_d            = '0;
          phase_d           = PH_HALTED;
          state_d           = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (phase_q != PH_DECODING || bitn_q == 3'd0) begin
          state_d = pend_valid_q ? ST_FLUSH : ST_IDLE;
        end else begin
          bitn_d  = bitn_q - 3'd1;
          state_d = ST_SHIFT;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_d        = pend_q;
          out_d.last   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= PH_IDLE;
      count_q      <= '0;
      pcode_q      <= '0;
      plen_q       <= '0;
      left_q       <= '0;
      maxlen_q     <= MaxLenReset;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      count_q      <= count_d;
      pcode_q      <= pcode_d;
      plen_q       <= plen_d;
      left_q       <= left_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) maxlen_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    byte_q   <= byte_d;
    bitn_q   <= bitn_d;
    ld_q     <= ld_d;
    hitsym_q <= hitsym_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full) else $error("entry count above capacity");
  a_plen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plen_q <= MaxLenLimit) else $error("partial length above 32");
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_valid_q) else $error("pending result left in idle");
  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FLUSH && out_free |=> out_valid_q && out_q.last)
    else $error("flush did not present a last result");

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the Huffman bitstream decoder: directed table, capacity fill, then random frames.
module testbench;
  import hbd_pkg::*;

  localparam int TableN = 256;

  typedef struct {
    hbd_in_t  req;
    bit       chk;
    hbd_out_t want;
  } dir_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i;
  logic [LenW-1:0] cfg_data_i;

  hbd_in_if  req_if ();
  hbd_out_if res_if ();

  huffman_bitstream_decoder_top #(.TABLE_ENTRIES(TableN)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_if),
    .out_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // shadow decoder state
  hbd_entry_t      code_rows [TableN];
  int              rows_used;
  logic [31:0]     shift_code;
  int              shift_len;
  logic [23:0]     syms_left;
  hbd_phase_e      frame_phase;
  logic [LenW-1:0] max_len;

  hbd_out_t        sym_q[$];
  int              errors, n_sent, n_results, n_errs_seen, n_pushed;
  int              src_idle, snk_idle;
  int              stall_reqs;
  dir_row_t        dir_rows[$];

  task automatic report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic int find_row(logic [31:0] code, logic [LenW-1:0] len);
    for (int i = 0; i < rows_used; i++)
      if (code_rows[i].code == code && code_rows[i].length == len) return i;
    return -1;
  endfunction

  function automatic void decode_request(hbd_in_t r);
    int at;
    int n;
    int lim;
    n = 0;
    case (r.opcode)
      OP_CLEAR: rows_used = 0;
      OP_LOAD: begin
        at = find_row(r.entry_code, r.entry_length);
        if (at >= 0) begin
          code_rows[at].symbol = r.entry_symbol;
        end else if (rows_used < TableN) begin
          code_rows[rows_used] = '{r.entry_symbol, r.entry_length, r.entry_code};
          rows_used++;
        end
      end
      OP_START: begin
        syms_left = r.symbol_count;
        shift_code = '0;
        shift_len = 0;
        frame_phase = (syms_left == 0) ? PH_DONE : PH_DECODING;
      end
      default: begin
        lim = (max_len == 0) ? 1 : (max_len > MaxLenLimit) ? 32 : int'(max_len);
        for (int b = 7; b >= 0; b--) begin
          if (frame_phase != PH_DECODING) break;
          shift_code = {shift_code[30:0], r.data_byte[b]};
          shift_len++;
          at = find_row(shift_code, shift_len[LenW-1:0]);
          if (at >= 0) begin
            syms_left = syms_left - 1'b1;
            sym_q.push_back('{code_rows[at].symbol, 1'b0, syms_left == 0, 1'b0});
            n++;
            shift_code = '0;
            shift_len = 0;
            if (syms_left == 0) frame_phase = PH_DONE;
          end else if (shift_len >= lim) begin
            sym_q.push_back('{16'h0, 1'b1, 1'b0, 1'b0});
            n++;
            shift_code = '0;
            shift_len = 0;
            frame_phase = PH_HALTED;
          end
        end
      end
    endcase
    if (n > 0) sym_q[sym_q.size()-1].last = 1'b1;
    n_pushed += n;
  endfunction

  function automatic hbd_in_t rand_req(hbd_op_e op);
    hbd_in_t r;
    r.opcode       = op;
    r.entry_symbol = SymW'($urandom());
    r.entry_length = LenW'($urandom());
    r.entry_code   = $urandom();
    r.symbol_count = CountW'($urandom());
    r.data_byte    = ByteW'($urandom());
    return r;
  endfunction

  function automatic hbd_in_t load_req(logic [15:0] sym, logic [5:0] len, logic [31:0] code);
    hbd_in_t r;
    r = rand_req(OP_LOAD);
    r.entry_symbol = sym;
    r.entry_length = len;
    r.entry_code   = code;
    return r;
  endfunction

  function automatic hbd_in_t start_req(logic [23:0] cnt);
    hbd_in_t r;
    r = rand_req(OP_START);
    r.symbol_count = cnt;
    return r;
  endfunction

  function automatic hbd_in_t data_req(logic [7:0] byte_v);
    hbd_in_t r;
    r = rand_req(OP_DATA);
    r.data_byte = byte_v;
    return r;
  endfunction

  task automatic send(hbd_in_t r);
    while ($urandom_range(99) < src_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    decode_request(r);
    n_sent++;
  endtask

  // results drained, then enough cycles for a byte that scans the whole table
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sym_q.size() != 0) @(posedge clk_i);
    repeat (2 * (8 * (2 * rows_used + 3) + 2) + 20) @(posedge clk_i);
  endtask

  task automatic set_max_len(logic [LenW-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    max_len = v;
  endtask

  // one frame of well-formed prefix codes with random content, with some noise mixed in
  task automatic random_frame(int lim, int stop_at);
    hbd_entry_t ents[$];
    bit         bits[$];
    int         k, len, lmax, cnt, pick, ok;
    logic [31:0] code;
    logic [7:0]  byte_v;
    lmax = (lim < 10) ? lim : 10;
    if ($urandom_range(4) != 0) send(rand_req(OP_CLEAR));
    k = $urandom_range(1, 6);
    for (int e = 0; e < k; e++) begin
      for (int t = 0; t < 20; t++) begin
        len = (lim >= 20 && $urandom_range(5) == 0) ? $urandom_range(17, lim)
                                                    : $urandom_range(1, lmax);
        code = $urandom() & ((len == 32) ? 32'hFFFF_FFFF : ((32'h1 << len) - 1));
        ok = 1;
        foreach (ents[j]) begin
          int m;
          m = (len < ents[j].length) ? len : int'(ents[j].length);
          if ((code >> (len - m)) == (ents[j].code >> (ents[j].length - m))) ok = 0;
        end
        if (ok) begin
          ents.push_back('{16'($urandom()), len[5:0], code});
          break;
        end
      end
    end
    if (ents.size() == 0) ents.push_back('{16'($urandom()), 6'd1, 32'd0});
    foreach (ents[j]) send(load_req(ents[j].symbol, ents[j].length, ents[j].code));
    if ($urandom_range(3) == 0) begin
      pick = $urandom_range(ents.size() - 1);
      ents[pick].symbol = 16'($urandom());
      send(load_req(ents[pick].symbol, ents[pick].length, ents[pick].code));
    end
    if ($urandom_range(5) == 0) send(load_req(16'($urandom()),
                                              $urandom_range(0, 1) ? 6'd0 : 6'd40,
                                              $urandom()));
    cnt = ($urandom_range(9) == 0) ? int'($urandom_range(1, 24'hFF_FFFF))
                                   : $urandom_range(1, 12);
    for (int s = 0; s < cnt + 2 && s < 30; s++) begin
      pick = $urandom_range(ents.size() - 1);
      for (int b = int'(ents[pick].length) - 1; b >= 0; b--) bits.push_back(ents[pick].code[b]);
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 4)) bits.push_back(1'($urandom_range(1)));
    end
    send(start_req(CountW'(cnt)));
    while (bits.size() != 0 && n_sent < stop_at) begin
      for (int b = 7; b >= 0; b--) byte_v[b] = (bits.size() != 0) ? bits.pop_front()
                                                                  : 1'($urandom_range(1));
      if ($urandom_range(19) == 0) send(rand_req(hbd_op_e'($urandom_range(1, 3))));
      send(data_req(byte_v));
    end
  endtask

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk_i) begin
    static int hold_left = 0;
    static int seen_reqs = 0;
    if (stall_reqs != seen_reqs) begin
      seen_reqs = stall_reqs;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk_i) begin
    hbd_out_t got, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.payload;
      n_results++;
      if (got.status) n_errs_seen++;
      if (sym_q.size() == 0) begin
        report($sformatf("unexpected result sym=%h st=%b done=%b last=%b",
                         got.symbol, got.status, got.frame_done, got.last));
      end else begin
        want = sym_q.pop_front();
        if (got.symbol != want.symbol)
          report($sformatf("symbol %h, want %h", got.symbol, want.symbol));
        if (got.status != want.status)
          report($sformatf("status %b, want %b", got.status, want.status));
        if (got.frame_done != want.frame_done)
          report($sformatf("frame_done %b, want %b", got.frame_done, want.frame_done));
        if (got.last != want.last)
          report($sformatf("last %b, want %b", got.last, want.last));
      end
    end
  end

  initial begin
    #(12 * 3_000_000);
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [LenW-1:0] settings [6];
    int lim, stop_at, base_n;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    cfg_we_i       = 1'b0;
    cfg_data_i     = '0;
    rows_used = 0; shift_code = '0; shift_len = 0; syms_left = '0;
    frame_phase = PH_IDLE; max_len = MaxLenReset;
    errors = 0; n_sent = 0; n_results = 0; n_errs_seen = 0; stall_reqs = 0;
    n_pushed = 0;
    src_idle = 25; snk_idle = 58;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, max length at its reset value
    dir_rows.push_back('{data_req(8'h00), 0, '0});              // data while idle
    dir_rows.push_back('{rand_req(OP_CLEAR), 0, '0});
    dir_rows.push_back('{load_req(16'hFFFF, 6'd1, 32'h0), 0, '0});
    dir_rows.push_back('{load_req(16'h0000, 6'd2, 32'h2), 0, '0});
    dir_rows.push_back('{load_req(16'h1234, 6'd32, 32'hFFFF_FFFF), 0, '0});
    dir_rows.push_back('{load_req(16'h5555, 6'd2, 32'h7), 0, '0});   // code wider than length
    dir_rows.push_back('{load_req(16'h0005, 6'd0, 32'h0), 0, '0});   // length zero
    dir_rows.push_back('{load_req(16'hAAAA, 6'd1, 32'h0), 0, '0});   // duplicate, last wins
    dir_rows.push_back('{start_req(24'd0), 0, '0});                   // zero count
    dir_rows.push_back('{data_req(8'hFF), 0, '0});                    // ignored when done
    dir_rows.push_back('{start_req(24'hFF_FFFF), 0, '0});
    dir_rows.push_back('{data_req(8'h00), 0, '0});
    dir_rows.push_back('{data_req(8'h80), 0, '0});
    dir_rows.push_back('{start_req(24'd1), 0, '0});
    dir_rows.push_back('{data_req(8'h00), 1, '{16'hAAAA, 1'b0, 1'b1, 1'b1}});
    dir_rows.push_back('{start_req(24'd3), 0, '0});
    dir_rows.push_back('{data_req(8'hC0), 0, '0});                    // partial carries over
    dir_rows.push_back('{data_req(8'hFF), 1, '{16'h0000, 1'b1, 1'b0, 1'b1}});
    dir_rows.push_back('{data_req(8'h00), 0, '0});                    // halted
    dir_rows.push_back('{start_req(24'd2), 0, '0});
    dir_rows.push_back('{data_req(8'h80), 0, '0});
    dir_rows.push_back('{start_req(24'd10), 0, '0});
    dir_rows.push_back('{data_req(8'hFF), 0, '0});
    dir_rows.push_back('{load_req(16'h0077, 6'd9, 32'h1FF), 0, '0}); // load mid-frame
    dir_rows.push_back('{data_req(8'h80), 0, '0});
    foreach (dir_rows[i]) begin
      base_n = n_pushed;
      send(dir_rows[i].req);
      if (dir_rows[i].chk && (n_pushed != base_n + 1 || sym_q[$] != dir_rows[i].want))
        report($sformatf("directed row %0d does not give the listed result", i));
    end
    settle();

    // fill the table past capacity, then overwrite a row while full
    set_max_len(6'd8);
    send(rand_req(OP_CLEAR));
    for (int i = 0; i < TableN; i++) send(load_req(i[15:0], 6'd8, 32'(i)));
    send(load_req(16'hDEAD, 6'd9, 32'h1FF));
    send(load_req(16'hBEEF, 6'd8, 32'h5));
    send(start_req(24'd6));
    send(data_req(8'h05));
    send(data_req(8'h00));
    send(data_req(8'hFF));
    send(data_req(8'($urandom())));
    send(rand_req(OP_CLEAR));
    settle();

    settings = '{MaxLenReset, 6'd0, 6'd1, MaxLenLimit, 6'd63, 6'($urandom_range(2, 31))};
    for (int p = 0; p < 6; p++) begin
      src_idle = (p < 2) ? 25 : (p < 4) ? 58 : 0;
      snk_idle = (p < 2) ? 58 : (p < 4) ? 25 : 0;
      set_max_len(settings[p]);
      lim = (settings[p] == 0) ? 1 : (settings[p] > MaxLenLimit) ? 32 : int'(settings[p]);
      stop_at = n_sent + 8;
      while (n_sent < stop_at) begin
        if (p == 4 && stall_reqs == 0) stall_reqs++;
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(1, 4)) send(rand_req(hbd_op_e'($urandom_range(0, 3))));
        end else begin
          random_frame(lim, stop_at);
        end
      end
      settle();
    end

    $display("ran %0d requests through %0d max-length settings; %0d results checked, %0d no-match",
             n_sent, 7, n_results, n_errs_seen);
    $display("covered table overflow, duplicates, restarts, zero counts and a long output stall");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
